// ===== src/bdc_pkg.sv =====
`default_nettype none

package bdc_pkg;

    localparam int CLK_W        = 28;
    localparam int BAUD_W       = 24;
    localparam int BRR_W        = 16;
    localparam int NUM_W        = 33;
    localparam int DEN_W        = 26;
    localparam int R100_W       = 7;
    localparam int MANT_W       = 12;
    localparam int FRAC_W       = 4;
    localparam int FRACX_W      = 11;
    localparam int PROD_W       = 22;

    localparam logic [R100_W:0]   PCT_SCALE    = 8'd100;
    localparam logic [FRACX_W-1:0] ROUND_OFFSET = 11'd50;
    localparam logic [FRACX_W-1:0] RECIP_100    = 11'd1311;
    localparam int                 RECIP_SHIFT  = 17;

    typedef struct packed {
        logic               valid;
        logic               by8;
        logic               baud_zero;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic [DEN_W-1:0]   rem;
        logic [R100_W-1:0]  r100;
        logic [NUM_W-1:0]   mant;
    } bdc_item_t;

    typedef struct packed {
        logic [BRR_W-1:0] brr_word;
        logic             overflow;
    } bdc_result_t;

    function automatic logic [FRAC_W-1:0] frac_round(input logic [R100_W-1:0] r100,
                                                     input logic by8);
        logic [FRACX_W-1:0] scaled;
        logic [PROD_W-1:0]  prod;
        logic [PROD_W-1:0]  quot;
        scaled = by8 ? ({4'd0, r100} << 3) : ({4'd0, r100} << 4);
        scaled = scaled + ROUND_OFFSET;
        prod   = PROD_W'(scaled) * PROD_W'(RECIP_100);
        quot   = prod >> RECIP_SHIFT;
        frac_round = by8 ? {1'b0, quot[FRAC_W-2:0]} : quot[FRAC_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/bdc_stage.sv =====
`default_nettype none

module bdc_stage
    import bdc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire bdc_item_t item_in,
    output bdc_item_t      item_reg
);

    bdc_item_t          item_next;
    logic [DEN_W:0]     part;
    logic               q_bit;
    logic [R100_W:0]    part100;
    logic               m_bit;

    always_comb begin
        part      = {item_in.rem, item_in.num[NUM_W-1]};
        q_bit     = part >= {1'b0, item_in.den};
        part100   = {item_in.r100, q_bit};
        m_bit     = part100 >= PCT_SCALE;

        item_next      = item_in;
        item_next.num  = {item_in.num[NUM_W-2:0], 1'b0};
        item_next.rem  = q_bit ? DEN_W'(part - {1'b0, item_in.den}) : part[DEN_W-1:0];
        item_next.r100 = m_bit ? R100_W'(part100 - PCT_SCALE) : part100[R100_W-1:0];
        item_next.mant = {item_in.mant[NUM_W-2:0], m_bit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bdc_out.sv =====
`default_nettype none

module bdc_out
    import bdc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bdc_item_t        tail,
    output logic                  en,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [BRR_W-1:0]      m_brr_word,
    output logic                  m_mantissa_overflow
);

    bdc_result_t res;
    bdc_result_t out_reg;
    bdc_result_t skid_reg;
    logic        out_valid_reg;
    logic        skid_valid_reg;

    // The skid register catches the pipeline tail when the output is stalled.
    always_comb begin
        res.overflow = tail.baud_zero | (|tail.mant[NUM_W-1:MANT_W]);
        res.brr_word = tail.baud_zero ? '0
                     : {tail.mant[MANT_W-1:0], frac_round(tail.r100, tail.by8)};
    end

    assign en = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || m_ready) begin
            out_reg       <= res;
            out_valid_reg <= tail.valid;
        end else if (tail.valid) begin
            skid_reg       <= res;
            skid_valid_reg <= 1'b1;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_brr_word          = out_reg.brr_word;
    assign m_mantissa_overflow = out_reg.overflow;

endmodule

`default_nettype wire

// ===== src/usart_baud_divider_calc_top.sv =====
// Channel  Direction  Handshake          Payload
// s_       in         s_valid, s_ready   s_clock_hz, s_baud_rate, s_mode
// m_       out        m_valid, m_ready   m_brr_word, m_mantissa_overflow
//
// A new transaction is taken every cycle while s_ready is high; each one passes through
// the 33 quotient-bit stages of the restoring divider and then the output register.
// Each stage also feeds its quotient bit into a running division by one hundred.
// Reset clears the valid bits of every stage and the output and skid registers.
// A stalled output parks one result in a skid register; only then does s_ready drop
// and the whole pipeline hold.
`default_nettype none

module usart_baud_divider_calc_top
    import bdc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CLK_W-1:0]  s_clock_hz,
    input  wire logic [BAUD_W-1:0] s_baud_rate,
    input  wire logic              s_mode,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [BRR_W-1:0]       m_brr_word,
    output logic                   m_mantissa_overflow
);

    bdc_item_t stage_q [0:NUM_W];
    logic      en;

    always_comb begin
        stage_q[0].valid     = s_valid;
        stage_q[0].by8       = s_mode;
        stage_q[0].baud_zero = (s_baud_rate == '0);
        stage_q[0].num       = (NUM_W'(s_clock_hz) << 4) + (NUM_W'(s_clock_hz) << 3)
                             + NUM_W'(s_clock_hz);
        stage_q[0].den       = s_mode ? (DEN_W'(s_baud_rate) << 1) : (DEN_W'(s_baud_rate) << 2);
        stage_q[0].rem       = '0;
        stage_q[0].r100      = '0;
        stage_q[0].mant      = '0;
    end

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        bdc_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .item_in  (stage_q[i]),
            .item_reg (stage_q[i+1])
        );
    end

    bdc_out u_out (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .tail                (stage_q[NUM_W]),
        .en                  (en),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_brr_word          (m_brr_word),
        .m_mantissa_overflow (m_mantissa_overflow)
    );

    assign s_ready = en;

endmodule

`default_nettype wire

// ===== src/bdc_checker.sv =====
`default_nettype none

module bdc_checker
    import bdc_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [BRR_W-1:0] m_brr_word,
    input wire logic             m_mantissa_overflow
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Output valid after reset.");

    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("Input not ready after reset.");

    // Back-pressure on the input only ever comes from a held output transaction.
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("Input stalled with no output transaction pending.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_brr_word)
                                && $stable(m_mantissa_overflow))
        else $error("Stalled output transaction changed.");

endmodule

bind usart_baud_divider_calc_top bdc_checker u_bdc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_brr_word          (m_brr_word),
    .m_mantissa_overflow (m_mantissa_overflow)
);

`default_nettype wire
